FILE: rtl/aabb_collision_resolve_defines.svh
// Assertion macros used by the checker file of aabb_collision_resolve.
// No dependencies.
`ifndef AABB_COLLISION_RESOLVE_DEFINES_SVH
`define AABB_COLLISION_RESOLVE_DEFINES_SVH

// Implication in the same cycle, off during reset.
`define AABB_ASSERT_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Implication into the next cycle, off during reset.
`define AABB_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

// Implication into the next cycle, also checked across reset.
`define AABB_ASSERT_NEXT_ALWAYS(label, clk, a, c) \
  label: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("assertion failed");

`endif

FILE: rtl/aabb_pkg.sv
// Types, constants and helpers for the aabb_collision_resolve pipeline.
// No dependencies.
package aabb_pkg;

  localparam int POS_W  = 32;
  localparam int EXT_W  = 31;
  localparam int MASS_W = 16;
  localparam int SUM_W  = MASS_W + 1;
  localparam int NUM_W  = POS_W + MASS_W + 1;
  localparam int Q_W    = POS_W;
  localparam int DIV_FIRST = 5;
  localparam int NSTG   = DIV_FIRST + Q_W + 1;

  typedef enum logic [2:0] {
    OUT_APART = 3'd0,
    OUT_VERT  = 3'd1,
    OUT_HORIZ = 3'd2,
    OUT_TIE   = 3'd3,
    OUT_ZERO  = 3'd4
  } outcome_t;

  typedef struct packed {
    logic signed [POS_W-1:0] ax;
    logic signed [POS_W-1:0] ay;
    logic signed [POS_W-1:0] bx;
    logic signed [POS_W-1:0] by;
    logic [MASS_W-1:0]       am;
    logic [MASS_W-1:0]       bm;
    logic                    afix;
    logic                    bfix;
    logic signed [POS_W:0]   dx;
    logic signed [POS_W:0]   dy;
    logic [POS_W-1:0]        sw;
    logic [POS_W-1:0]        sh;
    logic                    ovl;
    logic [POS_W-1:0]        px2;
    logic [POS_W-1:0]        py2;
    logic                    a_pos;
    outcome_t                outcome;
    logic                    vert;
    logic [POS_W-1:0]        p2;
    logic [SUM_W-1:0]        s;
    logic [NUM_W-1:0]        na;
    logic [NUM_W-1:0]        nb;
    logic [Q_W-1:0]          qa;
    logic [Q_W-1:0]          qb;
  } pipe_t;

  function automatic logic [POS_W-1:0] sat32(input logic signed [POS_W+1:0] v);
    logic signed [POS_W+1:0] hi;
    logic signed [POS_W+1:0] lo;
    hi = (POS_W+2)'(signed'({1'b0, {(POS_W-1){1'b1}}}));
    lo = -hi - (POS_W+2)'(1);
    if (v > hi) return hi[POS_W-1:0];
    if (v < lo) return lo[POS_W-1:0];
    return v[POS_W-1:0];
  endfunction

endpackage

FILE: rtl/aabb_collision_resolve.sv
// Pipelined 2D box-pair overlap test and push-out.
// Depends on aabb_pkg.
//
// Usage: one box pair enters per beat on the in channel (in_valid/in_ready);
// one result leaves per beat on the out channel (out_valid/out_ready).
// An accepted input beat passes through five front stages, then the
// 32-stage restoring divider (one quotient bit per stage for each box's
// mass share) and one output stage before it shows on out_valid.
// Throughput is one pair per cycle while the out channel takes results.
// The whole pipeline advances together: when the out channel holds a
// result that is not taken, every stage holds and in_ready drops in the
// same cycle, so nothing is lost or repeated. Empty slots do not block:
// in_ready is high whenever the output register is empty or being drained.
// Reset (rst, synchronous) clears all stage valid bits; payload is not reset.
// Outcome codes: apart, vertical push, horizontal push, tie, zero mass.
module aabb_collision_resolve (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [aabb_pkg::POS_W-1:0] a_pos_x,
  input  logic signed [aabb_pkg::POS_W-1:0] a_pos_y,
  input  logic [aabb_pkg::EXT_W-1:0]       a_width,
  input  logic [aabb_pkg::EXT_W-1:0]       a_height,
  input  logic [aabb_pkg::MASS_W-1:0]      a_mass,
  input  logic                             a_fixed,
  input  logic signed [aabb_pkg::POS_W-1:0] b_pos_x,
  input  logic signed [aabb_pkg::POS_W-1:0] b_pos_y,
  input  logic [aabb_pkg::EXT_W-1:0]       b_width,
  input  logic [aabb_pkg::EXT_W-1:0]       b_height,
  input  logic [aabb_pkg::MASS_W-1:0]      b_mass,
  input  logic                             b_fixed,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [aabb_pkg::POS_W-1:0] new_a_x,
  output logic signed [aabb_pkg::POS_W-1:0] new_a_y,
  output logic signed [aabb_pkg::POS_W-1:0] new_b_x,
  output logic signed [aabb_pkg::POS_W-1:0] new_b_y,
  output logic [2:0]                       outcome
);

  localparam int PW = aabb_pkg::POS_W;
  localparam int NS = aabb_pkg::NSTG;
  localparam int DF = aabb_pkg::DIV_FIRST;
  localparam int QW = aabb_pkg::Q_W;
  localparam int NW = aabb_pkg::NUM_W;

  aabb_pkg::pipe_t st      [NS];
  aabb_pkg::pipe_t st_next [NS];
  logic            vld     [NS];
  logic            en;

  assign en       = !vld[NS-1] || out_ready;
  assign in_ready = en;

  always_comb begin
    logic [PW:0]             adx;
    logic [PW:0]             ady;
    logic [PW+1:0]           adx2;
    logic [PW+1:0]           ady2;
    logic [NW:0]             ta;
    logic [NW:0]             tb;
    logic [PW:0]             half;
    logic [QW-1:0]           mva;
    logic [QW-1:0]           mvb;
    logic signed [PW+1:0]    da;
    logic signed [PW+1:0]    db;
    aabb_pkg::pipe_t         p;

    // stage 0: capture and differences
    p         = '0;
    p.ax      = a_pos_x;
    p.ay      = a_pos_y;
    p.bx      = b_pos_x;
    p.by      = b_pos_y;
    p.am      = a_mass;
    p.bm      = b_mass;
    p.afix    = a_fixed;
    p.bfix    = b_fixed;
    p.dx      = (PW+1)'(b_pos_x) - (PW+1)'(a_pos_x);
    p.dy      = (PW+1)'(b_pos_y) - (PW+1)'(a_pos_y);
    p.sw      = PW'(a_width) + PW'(b_width);
    p.sh      = PW'(a_height) + PW'(b_height);
    st_next[0] = p;

    // stage 1: magnitudes, overlap, doubled penetrations, mass sum
    p    = st[0];
    adx  = p.dx[PW] ? (PW+1)'(-p.dx) : p.dx;
    ady  = p.dy[PW] ? (PW+1)'(-p.dy) : p.dy;
    adx2 = {adx, 1'b0};
    ady2 = {ady, 1'b0};
    p.ovl = (adx2 < (PW+2)'(p.sw)) && (ady2 < (PW+2)'(p.sh));
    p.px2 = PW'((PW+2)'(p.sw) - adx2);
    p.py2 = PW'((PW+2)'(p.sh) - ady2);
    p.s   = aabb_pkg::SUM_W'(p.am) + aabb_pkg::SUM_W'(p.bm);
    st_next[1] = p;

    // stage 2: classify, pick axis and direction
    p       = st[1];
    p.vert  = p.px2 > p.py2;
    p.p2    = p.vert ? p.py2 : p.px2;
    // A moves up when it sits above B; right when at or right of B
    p.a_pos = p.vert ? p.dy[PW] : (p.dx[PW] || (p.dx == '0));
    if (!p.ovl) begin
      p.outcome = aabb_pkg::OUT_APART;
    end else if (!p.afix && !p.bfix && (p.s == '0)) begin
      p.outcome = aabb_pkg::OUT_ZERO;
    end else if (p.px2 == p.py2) begin
      p.outcome = aabb_pkg::OUT_TIE;
    end else if (p.vert) begin
      p.outcome = aabb_pkg::OUT_VERT;
    end else begin
      p.outcome = aabb_pkg::OUT_HORIZ;
    end
    st_next[2] = p;

    // stage 3: push times partner mass
    p    = st[2];
    p.na = NW'(p.p2) * NW'(p.bm);
    p.nb = NW'(p.p2) * NW'(p.am);
    st_next[3] = p;

    // stage 4: add S for round half up
    p    = st[3];
    p.na = p.na + NW'(p.s);
    p.nb = p.nb + NW'(p.s);
    p.qa = '0;
    p.qb = '0;
    st_next[4] = p;

    // divider: one quotient bit per stage against 2S shifted
    for (int i = 0; i < QW; i++) begin
      p  = st[DF+i-1];
      ta = (NW+1)'({p.s, 1'b0}) << (QW-1-i);
      tb = ta;
      if ((NW+1)'(p.na) >= ta) begin
        p.na = NW'((NW+1)'(p.na) - ta);
        p.qa[QW-1-i] = 1'b1;
      end
      if ((NW+1)'(p.nb) >= tb) begin
        p.nb = NW'((NW+1)'(p.nb) - tb);
        p.qb[QW-1-i] = 1'b1;
      end
      st_next[DF+i] = p;
    end

    // output stage: apply move, saturate
    p    = st[NS-2];
    half = ((PW+1)'(p.p2) + (PW+1)'(1)) >> 1;
    if (p.afix) begin
      mva = '0;
      mvb = half[PW-1:0];
    end else if (p.bfix) begin
      mva = half[PW-1:0];
      mvb = '0;
    end else begin
      mva = p.qa;
      mvb = p.qb;
    end
    da = p.a_pos ? signed'({2'b00, mva}) : -signed'({2'b00, mva});
    db = p.a_pos ? -signed'({2'b00, mvb}) : signed'({2'b00, mvb});
    if (p.outcome == aabb_pkg::OUT_VERT) begin
      p.ay = aabb_pkg::sat32((PW+2)'(p.ay) + da);
      p.by = aabb_pkg::sat32((PW+2)'(p.by) + db);
    end else if (p.outcome == aabb_pkg::OUT_HORIZ) begin
      p.ax = aabb_pkg::sat32((PW+2)'(p.ax) + da);
      p.bx = aabb_pkg::sat32((PW+2)'(p.bx) + db);
    end
    st_next[NS-1] = p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NS; k++) st[k] <= st_next[k];
    end
  end

  assign out_valid = vld[NS-1];
  assign new_a_x   = st[NS-1].ax;
  assign new_a_y   = st[NS-1].ay;
  assign new_b_x   = st[NS-1].bx;
  assign new_b_y   = st[NS-1].by;
  assign outcome   = st[NS-1].outcome;

endmodule

FILE: rtl/aabb_checker.sv
// Port-level checks for aabb_collision_resolve, bound to the top level.
// Depends on aabb_pkg and aabb_collision_resolve_defines.svh.
`include "aabb_collision_resolve_defines.svh"

module aabb_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [aabb_pkg::POS_W-1:0] new_a_x,
  input logic signed [aabb_pkg::POS_W-1:0] new_b_y,
  input logic [2:0]                        outcome
);

  logic [2*aabb_pkg::POS_W+2:0] res_bits;
  logic                         code_ok;

  assign res_bits = {new_a_x, new_b_y, outcome};
  assign code_ok  = (outcome == aabb_pkg::OUT_APART) || (outcome == aabb_pkg::OUT_VERT) ||
                    (outcome == aabb_pkg::OUT_HORIZ) || (outcome == aabb_pkg::OUT_TIE) ||
                    (outcome == aabb_pkg::OUT_ZERO);

  // a held result keeps its beat
  `AABB_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(res_bits))

  `AABB_ASSERT_NEXT_ALWAYS(a_rst_empty, clk, rst, !out_valid)

  `AABB_ASSERT_IMPLY(a_code, clk, rst, out_valid, code_ok)

  // input side only stalls behind a blocked output
  `AABB_ASSERT_IMPLY(a_no_bubble_stall, clk, rst, !out_valid || out_ready, in_ready)

endmodule

bind aabb_collision_resolve aabb_checker u_aabb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .new_a_x   (new_a_x),
  .new_b_y   (new_b_y),
  .outcome   (outcome)
);
